>>> rtl/gbrc_pkg.sv
// Shared types and constants of the Goldbach range checker.
package gbrc_pkg;

    // Smallest prime and smallest even number that the search uses.
    localparam int unsigned FIRST_PRIME = 2;
    localparam int unsigned FIRST_EVEN  = 4;

    // Answer of the primality tester for one candidate.
    typedef struct packed {
        logic done;
        logic prime;
    } t_prime_rsp;

endpackage

>>> rtl/gbrc_mod_serial.sv
// Bit-serial remainder unit: restoring division, one dividend bit per cycle.
module gbrc_mod_serial #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUMBER_WIDTH-1:0] i_dividend,
    input  logic [NUMBER_WIDTH-1:0] i_divisor,
    output logic                    o_done,
    output logic [NUMBER_WIDTH-1:0] o_rem
);

    localparam int W  = NUMBER_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_shift, n_shift;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_div, n_div;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    assign w_trial = {r_rem, r_shift[W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_shift = r_shift;
        n_rem   = r_rem;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_start) begin
            n_shift = i_dividend;
            n_div   = i_divisor;
            n_rem   = '0;
            n_cnt   = CW'(W);
        end else if (r_cnt != '0) begin
            n_shift = {r_shift[W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_diff[W-1:0];
            end else begin
                n_rem = w_trial[W-1:0];
            end
            n_cnt  = r_cnt - CW'(1);
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_div   <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/gbrc_prime_test.sv
// Trial-division primality tester built around the serial remainder unit.
module gbrc_prime_test #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUMBER_WIDTH-1:0] i_x,
    output gbrc_pkg::t_prime_rsp    o_rsp
);

    localparam int W = NUMBER_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHK  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]   r_state, n_state;
    logic [W-1:0] r_x, n_x;
    logic [W-1:0] r_d, n_d;
    logic [W:0]   r_sq, n_sq;   // always (d-1)^2, grown by 2d-1 per divisor step
    logic         r_done, n_done;
    logic         r_prime, n_prime;
    logic         w_mod_start;
    logic         w_mod_done;
    logic [W-1:0] w_rem;
    logic [W+1:0] w_sq_next;

    assign w_sq_next = {1'b0, r_sq} + {1'b0, r_d, 1'b0} - (W+2)'(1);

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_d         = r_d;
        n_sq        = r_sq;
        n_done      = 1'b0;
        n_prime     = r_prime;
        w_mod_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_x = i_x;
                    if (i_x < W'(gbrc_pkg::FIRST_PRIME)) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                    end else if (i_x == W'(gbrc_pkg::FIRST_PRIME)) begin
                        n_done  = 1'b1;
                        n_prime = 1'b1;
                    end else begin
                        n_d     = W'(gbrc_pkg::FIRST_PRIME);
                        n_sq    = (W+1)'(1);
                        n_state = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                if (r_sq <= {1'b0, r_x}) begin
                    w_mod_start = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    n_done  = 1'b1;
                    n_prime = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (w_mod_done) begin
                    if (w_rem == '0) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_sq    = w_sq_next[W:0];
                        n_d     = r_d + W'(1);
                        n_state = ST_CHK;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_prime <= n_prime;
        end
        r_x  <= n_x;
        r_d  <= n_d;
        r_sq <= n_sq;
    end

    gbrc_mod_serial #(
        .NUMBER_WIDTH(W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_x),
        .i_divisor  (r_d),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    assign o_rsp.done  = r_done;
    assign o_rsp.prime = r_prime;

endmodule

>>> rtl/goldbach_range_checker_top.sv
// Top level of the Goldbach range checker: search sequencer and output register.
// Odd n or n <= 2 skips the search: the sequencer goes from ST_IDLE to ST_DONE, then the output register.
// Otherwise each primality test of x runs the serial remainder unit once per trial divisor,
// up to floor(sqrt(x)) divisors, so the total grows steeply with n. Throughput: one word
// in flight; the next word is taken once the search goes idle. Reset: synchronous, active
// low; clears the sequencers and the output valid.
module goldbach_range_checker_top #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_number_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_holds,
    output logic [15:0] o_smaller_prime,
    output logic [15:0] o_larger_prime
);

    localparam int W = NUMBER_WIDTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TA    = 3'd1;
    localparam logic [2:0] ST_WA    = 3'd2;
    localparam logic [2:0] ST_TB    = 3'd3;
    localparam logic [2:0] ST_WB    = 3'd4;
    localparam logic [2:0] ST_NEXT  = 3'd5;
    localparam logic [2:0] ST_FOUND = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]           r_state, n_state;
    logic [W-1:0]         r_n, n_n;
    logic [W-1:0]         r_j, n_j;
    logic [W-1:0]         r_i, n_i;
    logic                 r_hold, n_hold;
    logic                 r_ovalid, n_ovalid;
    logic                 r_oholds, n_oholds;
    logic [15:0]          r_osmall, n_osmall;
    logic [15:0]          r_olarge, n_olarge;
    logic [31:0]          w_num_ext;
    logic [W-1:0]         w_num;
    logic [W-1:0]         w_rest;
    logic [W-1:0]         w_large;
    logic                 w_start;
    logic [W-1:0]         w_x;
    gbrc_pkg::t_prime_rsp w_rsp;

    assign w_num_ext = {16'b0, i_number_in};
    assign w_num     = w_num_ext[W-1:0];
    assign w_rest    = r_j - r_i;
    // n minus the smaller prime; r_j equals r_n whenever this is used.
    assign w_large   = r_n - r_i;
    assign w_start   = (r_state == ST_TA) || (r_state == ST_TB);
    assign w_x       = (r_state == ST_TB) ? w_rest : r_i;

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_j      = r_j;
        n_i      = r_i;
        n_hold   = r_hold;
        n_ovalid = r_ovalid && i_stall;
        n_oholds = r_oholds;
        n_osmall = r_osmall;
        n_olarge = r_olarge;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_n = w_num;
                    n_j = W'(gbrc_pkg::FIRST_EVEN);
                    n_i = W'(gbrc_pkg::FIRST_PRIME);
                    if (w_num <= W'(gbrc_pkg::FIRST_PRIME) || w_num[0]) begin
                        n_hold  = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_TA;
                    end
                end
            end
            ST_TA: begin
                n_state = ST_WA;
            end
            ST_WA: begin
                if (w_rsp.done) begin
                    n_state = w_rsp.prime ? ST_TB : ST_NEXT;
                end
            end
            ST_TB: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                if (w_rsp.done) begin
                    n_state = w_rsp.prime ? ST_FOUND : ST_NEXT;
                end
            end
            ST_NEXT: begin
                // If the candidate range for this even number is used up: no pair; else the next candidate.
                if (r_i == r_j - W'(gbrc_pkg::FIRST_PRIME)) begin
                    n_hold  = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    n_i     = r_i + W'(1);
                    n_state = ST_TA;
                end
            end
            ST_FOUND: begin
                if (r_j == r_n) begin
                    n_hold  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_j     = r_j + W'(gbrc_pkg::FIRST_PRIME);
                    n_i     = W'(gbrc_pkg::FIRST_PRIME);
                    n_state = ST_TA;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oholds = r_hold;
                    n_osmall = r_hold ? 16'(32'(r_i)) : 16'd0;
                    n_olarge = r_hold ? 16'(32'(w_large)) : 16'd0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_n      <= n_n;
        r_j      <= n_j;
        r_i      <= n_i;
        r_hold   <= n_hold;
        r_oholds <= n_oholds;
        r_osmall <= n_osmall;
        r_olarge <= n_olarge;
    end

    gbrc_prime_test #(
        .NUMBER_WIDTH(W)
    ) u_prime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_x     (w_x),
        .o_rsp   (w_rsp)
    );

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_holds         = r_oholds;
    assign o_smaller_prime = r_osmall;
    assign o_larger_prime  = r_olarge;

endmodule

>>> rtl/gbrc_checker.sv
// Port-level checker for the Goldbach range checker and its bind.
module gbrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_holds,
    input logic [15:0] o_smaller_prime,
    input logic [15:0] o_larger_prime
);

    // A word held back by the receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_holds)
            && $stable(o_smaller_prime) && $stable(o_larger_prime))
        else $error("output word changed while stalled");

    // A negative answer carries no pair.
    a_no_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_holds |-> o_smaller_prime == 16'd0 && o_larger_prime == 16'd0)
        else $error("pair reported without a positive answer");

    // A positive answer carries a pair with neither value below two.
    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_holds |-> o_smaller_prime >= 16'd2 && o_larger_prime >= 16'd2)
        else $error("reported pair holds a value below two");

    // Once a word is taken the block is busy, so the input side stalls.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after a word was taken");

endmodule

bind goldbach_range_checker_top gbrc_checker u_gbrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_holds         (o_holds),
    .o_smaller_prime (o_smaller_prime),
    .o_larger_prime  (o_larger_prime)
);

>>> bench/testbench.sv
// Self-checking bench for the Goldbach range checker: directed and random numbers, random idling.
`timescale 1ns / 1ps

module testbench;

    localparam int NUMBER_WIDTH = 16;

    typedef struct packed {
        logic        holds;
        logic [15:0] smaller;
        logic [15:0] larger;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_number_in = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_holds;
    logic [15:0] o_smaller_prime;
    logic [15:0] o_larger_prime;

    t_answer     pending_answers[$];
    int unsigned error_count = 0;
    bit          no_idle = 1'b0;
    int unsigned hold_request = 0;

    goldbach_range_checker_top #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_number_in    (i_number_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_holds        (o_holds),
        .o_smaller_prime(o_smaller_prime),
        .o_larger_prime (o_larger_prime)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit trial_prime(int unsigned x);
        int unsigned d;
        if (x < gbrc_pkg::FIRST_PRIME) return 1'b0;
        if (x == gbrc_pkg::FIRST_PRIME) return 1'b1;
        for (d = gbrc_pkg::FIRST_PRIME; (d - 1) * (d - 1) <= x; d++) begin
            if (x % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_answer goldbach_answer(logic [15:0] n);
        int unsigned num;
        int unsigned j;
        int unsigned i;
        int unsigned found;
        t_answer     ans;
        ans = '0;
        num = n;
        found = 0;
        if (num <= 2 || n[0]) return ans;
        for (j = gbrc_pkg::FIRST_EVEN; j <= num; j += 2) begin
            found = 0;
            for (i = gbrc_pkg::FIRST_PRIME; i <= j - 2; i++) begin
                if (trial_prime(i) && trial_prime(j - i)) begin
                    found = i;
                    break;
                end
            end
            // One even number without a pair ends the search with a zero answer.
            if (found == 0) return ans;
        end
        ans.holds = 1'b1;
        ans.smaller = 16'(found);
        ans.larger = 16'(num - found);
        return ans;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_number(input logic [15:0] n);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_number_in <= n;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_answers.push_back(goldbach_answer(n));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_answers.size() > 0) @(posedge i_clk);
    endtask

    // Result side: checks each accepted word and drives random stall.
    always @(posedge i_clk) begin : result_side
        static int unsigned stall_left = 0;
        t_answer            exp_ans;
        int unsigned        r;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_answers.size() == 0) begin
                $error("result word with no expected answer");
                error_count++;
            end else begin
                exp_ans = pending_answers.pop_front();
                if (o_holds !== exp_ans.holds) begin
                    $error("holds: expected %0d, actual %0d", exp_ans.holds, o_holds);
                    error_count++;
                end
                if (o_smaller_prime !== exp_ans.smaller) begin
                    $error("smaller_prime: expected %0d, actual %0d",
                           exp_ans.smaller, o_smaller_prime);
                    error_count++;
                end
                if (o_larger_prime !== exp_ans.larger) begin
                    $error("larger_prime: expected %0d, actual %0d",
                           exp_ans.larger, o_larger_prime);
                    error_count++;
                end
            end
        end
        if (hold_request != 0) begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (no_idle || r < 60) begin
                i_stall <= 1'b0;
            end else if (r < 95) begin
                stall_left = $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                stall_left = $urandom_range(10, 40);
                i_stall <= 1'b1;
            end
        end
    end

    // Odd numbers and numbers up to two skip the search and are answered with zeros.
    task automatic test_trivial_numbers();
        logic [15:0] trivial_set[9];
        trivial_set = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'hFFFD, 16'h8001,
                        16'hAAAB, 16'h5555};
        foreach (trivial_set[k]) send_number(trivial_set[k]);
    endtask

    task automatic test_small_evens();
        no_idle = 1'b1;
        for (int n = 4; n <= 20; n += 2) send_number(16'(n));
        no_idle = 1'b0;
    endtask

    task automatic test_larger_evens();
        send_number(16'd100);
        send_number(16'd128);
    endtask

    // The receiver holds off while words keep coming, so the block fills and stalls.
    task automatic test_backpressure();
        hold_request = 300;
        send_number(16'd7);
        send_number(16'd24);
        send_number(16'd2);
        send_number(16'd30);
        wait_drained();
        send_number(16'd4);
    endtask

    task automatic test_random_numbers();
        int unsigned r;
        logic [15:0] n;
        for (int k = 0; k < 75; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                n = 16'($urandom) | 16'd1;
            end else if (r < 50) begin
                n = ($urandom_range(0, 1) != 0) ? 16'd2 : 16'd0;
            end else if (r < 97) begin
                n = 16'($urandom_range(2, 32) * 2);
            end else begin
                n = 16'($urandom_range(33, 80) * 2);
            end
            send_number(n);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_number_in <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_trivial_numbers();
        test_small_evens();
        test_larger_evens();
        test_backpressure();
        test_random_numbers();
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (pending_answers.size() > 0) begin
            $error("%0d expected answers never arrived", pending_answers.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #160_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> goldbach_range_checker_top.f
rtl/gbrc_pkg.sv
rtl/gbrc_mod_serial.sv
rtl/gbrc_prime_test.sv
rtl/goldbach_range_checker_top.sv
rtl/gbrc_checker.sv
bench/testbench.sv
